// ----- sv/xxtea_block_encrypt_core_defines.svh -----
// assertion macros for the xxtea block encrypt core
// the enclosing module provides clock and reset
`ifndef XXTEA_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define XXTEA_BLOCK_ENCRYPT_CORE_DEFINES_SVH

// same-cycle implication
`define XBE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("xbe check failed");

// next-cycle implication
`define XBE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("xbe check failed");

`endif

// ----- sv/xbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package xbe_pkg;

   localparam int XBE_MAX_WORDS = 64;
   localparam int XBE_QDEPTH = 4;
   localparam int XBE_BW_W = 7;
   localparam int XBE_ROUND_W = 6;
   localparam int XBE_BASE_ROUNDS = 6;
   localparam logic [31:0] XBE_DELTA = 32'h9e3779b9;

   // register map, one 32-bit word each
   typedef enum logic [2:0] {
      XBE_REG_BLOCK_WORDS,
      XBE_REG_KEY0,
      XBE_REG_KEY1,
      XBE_REG_KEY2,
      XBE_REG_KEY3
   } xbe_reg_type;

   typedef enum logic [1:0] {
      BK_LOAD,
      BK_PRIME,
      BK_ROUND,
      BK_DRAIN
   } xbe_state_type;

   // one queued plaintext word, tagged by the front
   typedef struct packed {
      logic [31:0] word;
      logic        first;
      logic        closes;
   } xbe_entry_type;

   typedef struct packed {
      logic loading;
      logic draining;
      logic pop;
   } xbe_status_type;

   // xxtea mixing function, key word already selected
   function automatic logic [31:0] xbe_mix(input logic [31:0] y, input logic [31:0] z,
                                           input logic [31:0] sum, input logic [31:0] key);
      logic [31:0] a;
      logic [31:0] b;
      a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      b = (sum ^ y) + (key ^ z);
      return a ^ b;
   endfunction

   // 6 + 52 / n as a table
   function automatic logic [XBE_ROUND_W-1:0] xbe_rounds(input logic [XBE_BW_W-1:0] n);
      logic [XBE_ROUND_W-1:0] q;
      case (n) inside
         7'd1:        q = 6'd52;
         7'd2:        q = 6'd26;
         7'd3:        q = 6'd17;
         7'd4:        q = 6'd13;
         7'd5:        q = 6'd10;
         7'd6:        q = 6'd8;
         7'd7:        q = 6'd7;
         7'd8:        q = 6'd6;
         [7'd9:7'd10]:  q = 6'd5;
         [7'd11:7'd13]: q = 6'd4;
         [7'd14:7'd17]: q = 6'd3;
         [7'd18:7'd26]: q = 6'd2;
         [7'd27:7'd52]: q = 6'd1;
         default:     q = 6'd0;
      endcase
      return XBE_ROUND_W'(XBE_BASE_ROUNDS) + q;
   endfunction

endpackage

`default_nettype wire

// ----- sv/xbe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xbe_front #(
   parameter int MAX_WORDS = xbe_pkg::XBE_MAX_WORDS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [31:0]                    req_plain_word,
   input  logic [$clog2(MAX_WORDS+1)-1:0] n_words,
   input  logic                           restart,
   input  logic                           q_full,
   output logic                           push,
   output xbe_pkg::xbe_entry_type         entry
);
   import xbe_pkg::*;

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             closes;

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;
   assign closes    = (cnt_ff == n_words - CNT_W'(1));

   always_comb begin
      entry.word   = req_plain_word;
      entry.first  = (cnt_ff == '0);
      entry.closes = closes;
      cnt_in       = cnt_ff;
      if (restart) begin
         cnt_in = '0;
      end else if (push) begin
         cnt_in = closes ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/xbe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xbe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  xbe_pkg::xbe_entry_type entry_in,
   input  logic                   pop,
   output logic                   full,
   output logic                   valid,
   output xbe_pkg::xbe_entry_type entry_out
);
   import xbe_pkg::*;

   localparam int PTR_W = $clog2(XBE_QDEPTH);

   xbe_entry_type     slot_ff [XBE_QDEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [PTR_W:0]    count_ff;
   logic [PTR_W:0]    count_in;

   assign full      = (count_ff == (PTR_W+1)'(XBE_QDEPTH));
   assign valid     = (count_ff != '0);
   assign entry_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(XBE_QDEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(XBE_QDEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/xbe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xbe_back #(
   parameter int MAX_WORDS = xbe_pkg::XBE_MAX_WORDS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(MAX_WORDS+1)-1:0] n_words,
   input  logic [3:0][31:0]               key,
   input  logic                           q_valid,
   input  xbe_pkg::xbe_entry_type         q_entry,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_cipher_word,
   output logic                           rsp_last_word,
   output xbe_pkg::xbe_status_type        status
);
   import xbe_pkg::*;

   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam int IDX_W = $clog2(MAX_WORDS);
   localparam int RA_W  = $clog2(MAX_WORDS + 2);

   xbe_state_type          state_ff;
   xbe_state_type          state_in;
   logic [IDX_W-1:0]       wr_idx_ff;
   logic [IDX_W-1:0]       wr_idx_in;
   logic [31:0]            x_ff;
   logic [31:0]            x_in;
   logic [31:0]            z_ff;
   logic [31:0]            z_in;
   logic [31:0]            sum_ff;
   logic [31:0]            sum_in;
   logic [IDX_W-1:0]       p_ff;
   logic [IDX_W-1:0]       p_in;
   logic [XBE_ROUND_W-1:0] rounds_ff;
   logic [XBE_ROUND_W-1:0] rounds_in;
   logic                   fwd_ff;
   logic                   fwd_in;
   logic [CNT_W-1:0]       k_ff;
   logic [CNT_W-1:0]       k_in;
   logic                   rd_valid_ff;
   logic                   rd_valid_in;
   logic                   rd_last_ff;
   logic                   rd_last_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   out_last_ff;
   logic [31:0]            out_word_ff;

   logic [31:0]            mem [MAX_WORDS];
   logic [31:0]            rd_data_ff;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [31:0]            wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;

   logic [31:0]            y;
   logic [31:0]            new_word;
   logic [RA_W-1:0]        ra;
   logic [RA_W-1:0]        ra_mod;
   logic                   last_step;
   logic                   move_a;
   logic                   issue;
   logic [IDX_W-1:0]       load_idx;

   // y comes from the read port, or straight from z when that read hit the word just written
   assign y        = fwd_ff ? z_ff : rd_data_ff;
   assign new_word = x_ff + xbe_mix(y, z_ff, sum_ff, key[2'(p_ff) ^ sum_ff[3:2]]);
   assign last_step = (CNT_W'(p_ff) == n_words - CNT_W'(1));
   assign ra       = RA_W'(p_ff) + RA_W'(2);
   assign ra_mod   = (ra >= RA_W'(n_words)) ? ra - RA_W'(n_words) : ra;
   assign load_idx = q_entry.first ? '0 : wr_idx_ff;
   assign move_a   = rd_valid_ff & (~out_valid_ff | ~rsp_stall);

   always_comb begin
      state_in  = state_ff;
      wr_idx_in = wr_idx_ff;
      x_in      = x_ff;
      z_in      = z_ff;
      sum_in    = sum_ff;
      p_in      = p_ff;
      rounds_in = rounds_ff;
      fwd_in    = 1'b0;
      k_in      = k_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = p_ff;
      wr_data   = new_word;
      rd_en     = 1'b0;
      rd_addr   = '0;
      issue     = 1'b0;
      case (state_ff)
         BK_LOAD: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               wr_en     = 1'b1;
               wr_addr   = load_idx;
               wr_data   = q_entry.word;
               wr_idx_in = load_idx + IDX_W'(1);
               if (q_entry.first) begin
                  x_in = q_entry.word;
               end
               if (q_entry.closes) begin
                  z_in = q_entry.word;
                  k_in = '0;
                  state_in = (n_words == CNT_W'(1)) ? BK_DRAIN : BK_PRIME;
               end
            end
         end
         BK_PRIME: begin
            rd_en     = 1'b1;
            rd_addr   = IDX_W'(1);
            sum_in    = XBE_DELTA;
            p_in      = '0;
            rounds_in = xbe_rounds(XBE_BW_W'(n_words)) - XBE_ROUND_W'(1);
            state_in  = BK_ROUND;
         end
         BK_ROUND: begin
            wr_en   = 1'b1;
            wr_addr = p_ff;
            wr_data = new_word;
            z_in    = new_word;
            x_in    = y;
            rd_en   = 1'b1;
            rd_addr = ra_mod[IDX_W-1:0];
            fwd_in  = (ra_mod[IDX_W-1:0] == p_ff);
            if (last_step) begin
               p_in = '0;
               if (rounds_ff == '0) begin
                  k_in     = '0;
                  state_in = BK_DRAIN;
               end else begin
                  rounds_in = rounds_ff - XBE_ROUND_W'(1);
                  sum_in    = sum_ff + XBE_DELTA;
               end
            end else begin
               p_in = p_ff + IDX_W'(1);
            end
         end
         BK_DRAIN: begin
            issue   = (k_ff != n_words) & (~rd_valid_ff | move_a);
            rd_en   = issue;
            rd_addr = k_ff[IDX_W-1:0];
            if (issue) begin
               k_in = k_ff + CNT_W'(1);
            end
            if (k_ff == n_words && !rd_valid_ff) begin
               state_in = BK_LOAD;
            end
         end
         default: begin
            state_in = BK_LOAD;
         end
      endcase
      rd_valid_in  = issue | (rd_valid_ff & ~move_a);
      rd_last_in   = issue ? (k_ff == n_words - CNT_W'(1)) : rd_last_ff;
      out_valid_in = move_a | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_LOAD;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_idx_ff  <= wr_idx_in;
      x_ff       <= x_in;
      z_ff       <= z_in;
      sum_ff     <= sum_in;
      p_ff       <= p_in;
      rounds_ff  <= rounds_in;
      fwd_ff     <= fwd_in;
      k_ff       <= k_in;
      rd_last_ff <= rd_last_in;
      if (move_a) begin
         out_word_ff <= rd_data_ff;
         out_last_ff <= rd_last_ff;
      end
   end

   // block store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_cipher_word = out_word_ff;
   assign rsp_last_word   = out_last_ff;

   assign status.loading  = (state_ff == BK_LOAD);
   assign status.draining = (state_ff == BK_DRAIN);
   assign status.pop      = q_pop;

endmodule

`default_nettype wire

// ----- sv/xxtea_block_encrypt_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
//  channel   ports                            direction  content
//  req       req_valid / req_stall            in         plain_word, one per transfer
//  rsp       rsp_valid / rsp_stall            out        cipher_word, last_word
//  csr       psel penable pwrite paddr ...    in / out   block_words, key words 0..3
//
//  a block of n words is loaded, primed, run through 6 + 52/n rounds and then
//  drained; the rounds make a single word update per cycle on the one-write,
//  one-read block store
//  a one-word block skips the rounds and is returned as it came
//  up to four words of the next block queue up while a block is worked on
//  reset is synchronous and clears control state only; no clearing pass

module xxtea_block_encrypt_core #(
   parameter int MAX_WORDS = xbe_pkg::XBE_MAX_WORDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_plain_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_cipher_word,
   output logic        rsp_last_word,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import xbe_pkg::*;

   `include "xxtea_block_encrypt_core_defines.svh"

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   logic [XBE_BW_W-1:0] bw_ff;
   logic [XBE_BW_W-1:0] bw_in;
   logic [3:0][31:0]    key_ff;
   logic [3:0][31:0]    key_in;
   logic                csr_wr;
   logic                restart;
   logic [CNT_W-1:0]    n_words;
   xbe_reg_type         reg_sel;

   logic                push;
   xbe_entry_type       front_entry;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   xbe_entry_type       q_entry;
   xbe_status_type      bk_status;

   // register port: always ready, write on the access phase
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign reg_sel = xbe_reg_type'(paddr[4:2]);

   always_comb begin
      bw_in   = bw_ff;
      key_in  = key_ff;
      restart = 1'b0;
      if (csr_wr) begin
         case (reg_sel)
            XBE_REG_BLOCK_WORDS: begin
               bw_in   = pwdata[XBE_BW_W-1:0];
               restart = 1'b1;   // drops any partly loaded block
            end
            XBE_REG_KEY0: key_in[0] = pwdata;
            XBE_REG_KEY1: key_in[1] = pwdata;
            XBE_REG_KEY2: key_in[2] = pwdata;
            XBE_REG_KEY3: key_in[3] = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         XBE_REG_BLOCK_WORDS: prdata = {{(32-XBE_BW_W){1'b0}}, bw_ff};
         XBE_REG_KEY0:        prdata = key_ff[0];
         XBE_REG_KEY1:        prdata = key_ff[1];
         XBE_REG_KEY2:        prdata = key_ff[2];
         XBE_REG_KEY3:        prdata = key_ff[3];
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff  <= XBE_BW_W'(64);
         key_ff <= '0;
      end else begin
         bw_ff  <= bw_in;
         key_ff <= key_in;
      end
   end

   // zero words behaves as one, oversize saturates at the store depth
   always_comb begin
      if (bw_ff == '0) begin
         n_words = CNT_W'(1);
      end else if (bw_ff > XBE_BW_W'(MAX_WORDS)) begin
         n_words = CNT_W'(MAX_WORDS);
      end else begin
         n_words = CNT_W'(bw_ff);
      end
   end

   // front: takes transfers and tags block start and end
   xbe_front #(
      .MAX_WORDS (MAX_WORDS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_plain_word (req_plain_word),
      .n_words        (n_words),
      .restart        (restart),
      .q_full         (q_full),
      .push           (push),
      .entry          (front_entry)
   );

   // short queue between front and back
   xbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry_in  (front_entry),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .entry_out (q_entry)
   );

   // back: block store, round engine and result output
   xbe_back #(
      .MAX_WORDS (MAX_WORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .n_words         (n_words),
      .key             (key_ff),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cipher_word (rsp_cipher_word),
      .rsp_last_word   (rsp_last_word),
      .status          (bk_status)
   );

   // effective block size always within the store
   `XBE_ASSERT_NOW(a_n_range, 1'b1, n_words != '0 && n_words <= CNT_W'(MAX_WORDS))
   // results only start while the back is draining the store
   `XBE_ASSERT_NOW(a_rsp_from_drain, $rose(rsp_valid), $past(bk_status.draining))
   // the queue only drains into the store while loading
   `XBE_ASSERT_NOW(a_pop_in_load, bk_status.pop, bk_status.loading && q_valid)
   // a word taken from the queue leaves the back loading, starting rounds or, for a one-word block, draining
   `XBE_ASSERT_NEXT(a_pop_then_no_rsp_start, bk_status.pop, !$rose(rsp_valid))

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   import xbe_pkg::*;

   localparam int          CLOCK_PERIOD = 8;
   localparam int          RESET_CYCLES = 10;
   localparam int          MAX_WORDS    = XBE_MAX_WORDS;
   localparam logic [31:0] CIPHER_DELTA = 32'h9e3779b9;
   // quiet time after the last result before a register write: lets any
   // words still queued in front of the core reach the block store
   localparam int          SETTLE_CYCLES = 20;
   // long receiver hold-off for the back-pressure test
   localparam int          HOLD_OFF_CYCLES = 400;
   // watchdog: a full-size block's rounds and the receiver hold-off both run
   // without a transfer, and this is many times the longer of the two
   localparam int          QUIET_LIMIT = 4000;
   localparam int          END_CYCLES  = 200;

   // one expected word on the result channel
   typedef struct {
      logic [31:0] cipher;
      logic        last;
   } cipher_result_type;

   // ports of the block, every input known from time zero
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [31:0] req_plain_word = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [31:0] rsp_cipher_word;
   logic        rsp_last_word;
   logic        psel           = 1'b0;
   logic        penable        = 1'b0;
   logic        pwrite         = 1'b0;
   logic [4:0]  paddr          = '0;
   logic [31:0] pwdata         = '0;
   logic [31:0] prdata;
   logic        pready;

   // model state: the block being collected, the register copies
   logic [31:0] plain_store [MAX_WORDS];
   int          words_held;
   logic [6:0]  size_reg;
   logic [31:0] key_words [4];

   // words still owed by the block, oldest first
   cipher_result_type pending_ciphers [$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // idling, in percent of cycles, per side
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // hold-off requests from the test sequence, served by the receiver
   int holds_asked  = 0;
   int holds_served = 0;
   int hold_left    = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   xxtea_block_encrypt_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_plain_word  (req_plain_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cipher_word (rsp_cipher_word),
      .rsp_last_word   (rsp_last_word),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // ------------------------------------------------------------------
   // cipher model
   // ------------------------------------------------------------------

   // words per block as the core sees it: zero means one, above the
   // store size saturates
   function automatic int effective_size();
      if (size_reg == 0) begin
         return 1;
      end
      if (size_reg > MAX_WORDS) begin
         return MAX_WORDS;
      end
      return size_reg;
   endfunction

   function automatic logic [31:0] round_mix(input logic [31:0] y, input logic [31:0] z,
                                             input logic [31:0] total,
                                             input logic [31:0] key);
      logic [31:0] shifted;
      logic [31:0] keyed;
      shifted = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      keyed   = (total ^ y) + (key ^ z);
      return shifted ^ keyed;
   endfunction

   // in-place encryption of the first n store words
   function automatic void encipher_store(input int n);
      logic [31:0] total;
      logic [31:0] y;
      logic [31:0] z;
      int          rounds;
      int          sel;
      if (n < 2) begin
         return;
      end
      rounds = 6 + 52 / n;
      total  = '0;
      z      = plain_store[n-1];
      repeat (rounds) begin
         total = total + CIPHER_DELTA;
         sel   = (total >> 2) & 3;
         for (int p = 0; p < n - 1; p++) begin
            y = plain_store[p+1];
            plain_store[p] = plain_store[p] + round_mix(y, z, total, key_words[(p & 3) ^ sel]);
            z = plain_store[p];
         end
         y = plain_store[0];
         plain_store[n-1] = plain_store[n-1]
                          + round_mix(y, z, total, key_words[((n - 1) & 3) ^ sel]);
         z = plain_store[n-1];
      end
   endfunction

   // one accepted word; a completing word queues the whole enciphered block
   function automatic void predict_plain_word(input logic [31:0] word);
      cipher_result_type result;
      int                n;
      n = effective_size();
      if (words_held >= n) begin
         words_held = 0;
      end
      plain_store[words_held] = word;
      words_held++;
      if (words_held < n) begin
         return;
      end
      encipher_store(n);
      for (int k = 0; k < n; k++) begin
         result.cipher = plain_store[k];
         result.last   = (k == n - 1);
         pending_ciphers.push_back(result);
      end
      words_held = 0;
   endfunction

   function automatic void apply_reg_write(input xbe_reg_type index, input logic [31:0] value);
      case (index)
         XBE_REG_BLOCK_WORDS: begin
            // a new block size throws away a partly loaded block
            size_reg   = value[6:0];
            words_held = 0;
         end
         XBE_REG_KEY0, XBE_REG_KEY1, XBE_REG_KEY2, XBE_REG_KEY3: begin
            key_words[index - XBE_REG_KEY0] = value;
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // drivers, all inputs change on the falling edge
   // ------------------------------------------------------------------

   // one word on the input channel, predicted at the accepting edge
   task automatic send_plain(input logic [31:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_plain_word <= word;
      do @(posedge clock); while (req_stall);
      predict_plain_word(word);
   endtask

   // setup cycle then access cycle; the register takes the value at the
   // edge where the access completes
   task automatic write_reg(input xbe_reg_type index, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      apply_reg_write(index, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // sender goes quiet until every owed word has come back, then lets the
   // core settle so a register write finds it idle
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_ciphers.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
      write_reg(XBE_REG_KEY0, k0);
      write_reg(XBE_REG_KEY1, k1);
      write_reg(XBE_REG_KEY2, k2);
      write_reg(XBE_REG_KEY3, k3);
   endtask

   // plaintext with the all-zero and all-one words turning up often
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_key();
      case ($urandom_range(6))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // mostly short blocks, a few pass-through and full-size or oversized ones
   function automatic logic [6:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) begin
         return 7'($urandom_range(1));
      end
      if (roll < 10) begin
         return 7'($urandom_range(MAX_WORDS, 127));
      end
      return 7'($urandom_range(2, 12));
   endfunction

   // ------------------------------------------------------------------
   // receiver: random stall, or a long hold-off when the sequence asks
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_OFF_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // result checking: every transfer against the oldest owed word
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      cipher_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ciphers.size() == 0) begin
            report_mismatch("unexpected word", rsp_cipher_word, '0);
         end else begin
            want = pending_ciphers.pop_front();
            if (rsp_cipher_word !== want.cipher) begin
               report_mismatch("cipher_word", rsp_cipher_word, want.cipher);
            end
            if (rsp_last_word !== want.last) begin
               report_mismatch("last_word", 32'(rsp_last_word), 32'(want.last));
            end
         end
      end
   end

   // watchdog: any transfer on any channel resets the quiet count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // size zero and one: words come back untouched, each marked last;
   // also a size write whose upper bits fall outside the register
   task automatic test_pass_through();
      write_key($urandom(), $urandom(), $urandom(), $urandom());
      write_reg(XBE_REG_BLOCK_WORDS, 32'h0000_0000);
      send_plain(32'h0000_0000);
      send_plain(32'hffff_ffff);
      drain_results();
      write_reg(XBE_REG_BLOCK_WORDS, 32'h0000_0001);
      send_plain(32'ha5a5_5a5a);
      drain_results();
      // only the low seven bits count, so this is size zero again
      write_reg(XBE_REG_BLOCK_WORDS, 32'hffff_ff80);
      send_plain(32'h8000_0001);
      drain_results();
   endtask

   // smallest real blocks with all-one and all-zero keys
   task automatic test_key_extremes();
      write_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      write_reg(XBE_REG_BLOCK_WORDS, 32'd2);
      send_plain(32'h0000_0000);
      send_plain(32'hffff_ffff);
      drain_results();
      write_key('0, '0, '0, '0);
      write_reg(XBE_REG_BLOCK_WORDS, 32'd3);
      send_plain(32'hffff_ffff);
      send_plain(32'h0000_0000);
      send_plain(32'h1234_5678);
      drain_results();
   endtask

   // a size write part way through a block discards the words so far
   task automatic test_size_change_mid_block();
      write_reg(XBE_REG_BLOCK_WORDS, 32'd4);
      repeat (3) send_plain(pick_word());
      drain_results();
      write_reg(XBE_REG_BLOCK_WORDS, 32'd5);
      repeat (5) send_plain(pick_word());
      drain_results();
   endtask

   // the key is taken when the block completes, not when it starts
   task automatic test_key_change_mid_block();
      write_reg(XBE_REG_BLOCK_WORDS, 32'd4);
      repeat (2) send_plain(pick_word());
      drain_results();
      write_reg(XBE_REG_KEY0, $urandom());
      write_reg(XBE_REG_KEY3, 32'hffff_ffff);
      repeat (2) send_plain(pick_word());
      drain_results();
   endtask

   // receiver holds off for a long stretch while words keep coming, so
   // the input queue fills and the core must stall its input
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(XBE_REG_BLOCK_WORDS, 32'd2);
      holds_asked = holds_asked + 1;
      repeat (16) send_plain(pick_word());
      drain_results();
   endtask

   // phases of random blocks under one idling pattern; each phase writes
   // a fresh size and key, and some end in a broken, half-sent block that
   // the next size write throws away
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int items, input logic [6:0] first_size);
      logic [31:0] size_word;
      int          sent;
      int          phase_no;
      int          n;
      int          blocks;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent          = 0;
      phase_no      = 0;
      while (sent < items) begin
         size_word      = $urandom();
         size_word[6:0] = (phase_no == 0) ? first_size : pick_size();
         write_reg(XBE_REG_BLOCK_WORDS, size_word);
         write_key(pick_key(), pick_key(), pick_key(), pick_key());
         n      = effective_size();
         blocks = (n > 16) ? 1 : $urandom_range(1, 4);
         repeat (blocks * n) begin
            send_plain(pick_word());
            sent++;
         end
         if (n > 1 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, n - 1)) begin
               send_plain(pick_word());
               sent++;
            end
         end
         drain_results();
         phase_no++;
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      words_held = 0;
      size_reg   = 7'(MAX_WORDS);
      for (int k = 0; k < 4; k++) begin
         key_words[k] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pass_through();
      test_key_extremes();
      test_size_change_mid_block();
      test_key_change_mid_block();
      test_back_pressure();
      // sender mostly busy, receiver mostly stalling, first a full block
      test_random_traffic(9, 87, 125, 7'(MAX_WORDS));
      // the other way round, first an oversized block that saturates
      test_random_traffic(87, 9, 125, 7'd127);
      // no idling on either side
      test_random_traffic(0, 0, 125, 7'($urandom_range(MAX_WORDS + 1, 126)));

      drain_results();
      // catch any stray word after the last block
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
